### rtl/periodic_oneshot_timer_bank_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer bank
// Shared concurrent assertion forms, clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_BANK_ASSERT_SVH
`define PERIODIC_ONESHOT_TIMER_BANK_ASSERT_SVH

// same-cycle implication
`define POT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// next-cycle implication
`define POT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

### rtl/pot_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Codes, command and result types, saturating helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pot_pkg;

  localparam int unsigned TW   = 48;
  localparam int unsigned IVW  = 32;
  localparam int unsigned CNTW = 16;

  localparam logic [TW-1:0] WAKE_CAP = 48'd60000;

  localparam logic [1:0] REQ_EVAL  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  localparam logic [1:0] SM_IDLE    = 2'd0;
  localparam logic [1:0] SM_ALWAYS  = 2'd1;
  localparam logic [1:0] SM_RUNNING = 2'd2;

  localparam logic [1:0] RK_FIRE = 2'd0;
  localparam logic [1:0] RK_WAKE = 2'd1;
  localparam logic [1:0] RK_ACK  = 2'd2;

  localparam logic [2:0] CFG_IV0    = 3'd0;
  localparam logic [2:0] CFG_IV1    = 3'd1;
  localparam logic [2:0] CFG_IV2    = 3'd2;
  localparam logic [2:0] CFG_IV3    = 3'd3;
  localparam logic [2:0] CFG_REPEAT = 3'd4;

  typedef enum logic [1:0] {
    OP_EVAL,
    OP_START,
    OP_STOP
  } op_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DIV,
    BS_FIRE,
    BS_WAKE,
    BS_WEMIT,
    BS_ACK
  } back_state_e;

  typedef struct packed {
    op_e           op;
    logic [1:0]    idx;
    logic [1:0]    mode;
    logic [TW-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      idx;
    logic [CNTW-1:0] cnt;
    logic [TW-1:0]   wake;
    logic            acc;
    logic            run;
    logic            last;
  } res_t;

  function automatic logic [TW-1:0] sat48(input logic [TW:0] s);
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

endpackage

### rtl/pot_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the request front end and the execution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pot_cmd_fifo
  import pot_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/pot_div.sv
// ----------------------------------------------------------------------------
// Catch-up divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pot_div
  import pot_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [TW-1:0]   dividend_i,
  input  logic [IVW-1:0]  divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [TW-1:0]   quo_o,
  output logic [IVW-1:0]  rem_o
);

  logic [TW-1:0]  quo_q;
  logic [IVW-1:0] rem_q, dvs_q;
  logic [5:0]     cnt_q;
  logic           busy_q, done_q;
  logic [IVW:0]   sh, diff;
  logic           take;

  assign sh     = {rem_q, quo_q[TW-1]};
  assign diff   = sh - {1'b0, dvs_q};
  assign take   = (sh >= {1'b0, dvs_q});
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TW-2:0], take};
      rem_q <= take ? diff[IVW-1:0] : sh[IVW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(TW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/pot_back.sv
// ----------------------------------------------------------------------------
// Timer execution engine
// Owns timer state; runs evaluate, start and stop commands one at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pot_back
  import pot_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic [3:0][IVW-1:0]   interval_i,
  input  logic [3:0]            repeat_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output res_t                  res_o
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned PW = IW + 1;

  back_state_e          state_q, state_d;
  cmd_t                 cmd_q;
  logic [PW-1:0]        ptr_q, ptr_d;
  logic [NUM_TIMERS-1:0] armed_q;
  logic [TW-1:0]        expiry_q [NUM_TIMERS];
  logic [TW-1:0]        wake_q, wake_d;
  logic                 use_div_q, use_div_d;
  res_t                 out_q, out_d;
  logic                 out_valid_q;

  logic                 in_range, cur_armed, periodic, due, need_div, out_free;
  logic [IW-1:0]        tix;
  logic [TW-1:0]        cur_exp, diff, fire_exp;
  logic [IVW-1:0]       iv, addv;
  logic [TW:0]          sum_now, sum_exp, sum_start, sum_cap;
  logic [TW:0]          kq;
  logic [CNTW-1:0]      fire_cnt;
  logic                 go;

  logic                 div_start, div_busy, div_done;
  logic [TW-1:0]        div_quo;
  logic [IVW-1:0]       div_rem;

  logic                 exp_we, arm_we, arm_wd, out_load;
  logic [TW-1:0]        exp_wd;

  pot_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (iv),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign in_range  = (ptr_q < PW'(NUM_TIMERS));
  assign tix       = ptr_q[IW-1:0];
  assign cur_exp   = expiry_q[tix];
  assign cur_armed = in_range && armed_q[tix];
  assign iv        = interval_i[ptr_q[1:0]];
  assign periodic  = repeat_i[ptr_q[1:0]];
  assign due       = cur_armed && (cur_exp <= cmd_q.now);
  assign diff      = cmd_q.now - cur_exp;
  assign need_div  = periodic && (iv != '0) && (diff > {16'b0, iv});
  assign out_free  = !out_valid_q || !out_stall_i;

  // catch-up: expiry = now - r + (r ? iv : 0), k = q + (r != 0)
  assign addv      = (div_rem != '0) ? (iv - div_rem) : '0;
  assign sum_now   = {1'b0, cmd_q.now} + {17'b0, addv};
  assign sum_exp   = {1'b0, cur_exp} + {17'b0, iv};
  assign sum_start = {1'b0, cmd_q.now} + {17'b0, iv};
  assign sum_cap   = {1'b0, cmd_q.now} + {1'b0, WAKE_CAP};
  assign kq        = {1'b0, div_quo} + {{TW{1'b0}}, (div_rem != '0)};
  assign fire_cnt  = !use_div_q ? 16'd1 : ((|kq[TW:CNTW]) ? {CNTW{1'b1}} : kq[CNTW-1:0]);
  assign fire_exp  = (iv == '0) ? cmd_q.now : (use_div_q ? sat48(sum_now) : sat48(sum_exp));

  assign go = ((cmd_q.mode == SM_IDLE) && !cur_armed) || (cmd_q.mode == SM_ALWAYS) ||
              ((cmd_q.mode == SM_RUNNING) && cur_armed);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    wake_d    = wake_q;
    use_div_d = use_div_q;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    exp_we    = 1'b0;
    exp_wd    = fire_exp;
    arm_we    = 1'b0;
    arm_wd    = 1'b0;
    out_load  = 1'b0;
    out_d     = '0;
    case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          ptr_d     = (cmd_i.op == OP_EVAL) ? '0 : PW'(cmd_i.idx);
          state_d   = (cmd_i.op == OP_EVAL) ? BS_SCAN : BS_ACK;
        end
      end
      BS_SCAN: begin
        if (!in_range) begin
          wake_d  = sat48(sum_cap);
          ptr_d   = '0;
          state_d = BS_WAKE;
        end else if (due) begin
          if (need_div) begin
            div_start = 1'b1;
            state_d   = BS_DIV;
          end else begin
            use_div_d = 1'b0;
            state_d   = BS_FIRE;
          end
        end else begin
          ptr_d = ptr_q + PW'(1);
        end
      end
      BS_DIV: begin
        if (div_done) begin
          use_div_d = 1'b1;
          state_d   = BS_FIRE;
        end
      end
      BS_FIRE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = RK_FIRE;
          out_d.idx  = ptr_q[1:0];
          out_d.cnt  = fire_cnt;
          out_d.run  = periodic;
          exp_we     = periodic;
          arm_we     = !periodic;
          arm_wd     = 1'b0;
          ptr_d      = ptr_q + PW'(1);
          state_d    = BS_SCAN;
        end
      end
      BS_WAKE: begin
        if (in_range) begin
          if (cur_armed && (cur_exp < wake_q)) begin
            wake_d = cur_exp;
          end
          ptr_d = ptr_q + PW'(1);
        end else begin
          state_d = BS_WEMIT;
        end
      end
      BS_WEMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = RK_WAKE;
          out_d.wake = wake_q;
          out_d.last = 1'b1;
          state_d    = BS_IDLE;
        end
      end
      BS_ACK: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = RK_ACK;
          out_d.idx  = cmd_q.idx;
          out_d.last = 1'b1;
          if (in_range) begin
            if (cmd_q.op == OP_STOP) begin
              arm_we    = 1'b1;
              out_d.acc = 1'b1;
            end else begin
              out_d.acc = go;
              out_d.run = go || cur_armed;
              exp_we    = go;
              exp_wd    = sat48(sum_start);
              arm_we    = go;
              arm_wd    = 1'b1;
            end
          end
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      expiry_q[tix] <= exp_wd;
    end
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    wake_q    <= wake_d;
    use_div_q <= use_div_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      ptr_q       <= '0;
      armed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (arm_we) begin
        armed_q[tix] <= arm_wd;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

`include "periodic_oneshot_timer_bank_assert.svh"

  `POT_ASSERT_NOW(a_div_running, (state_q == BS_DIV), (div_busy || div_done))
  `POT_ASSERT_NOW(a_fire_not_last, (out_valid_q && (out_q.kind == RK_FIRE)), !out_q.last)
  `POT_ASSERT_NEXT(a_fire_advances, (state_q == BS_FIRE) && out_free, (state_q == BS_SCAN))
  `POT_ASSERT_NOW(a_pop_idle, cmd_pop_o, (state_q == BS_IDLE))

endmodule

### rtl/periodic_oneshot_timer_bank.sv
// ----------------------------------------------------------------------------
// Periodic / one-shot timer bank
// Request front end, command queue and execution engine for a small pool
// of software-style timers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the valid/stall input channel: evaluate (fire every
//   due timer, then report the next wake time), start or stop. A request of
//   type 3 is transferred and dropped. Results leave on the output channel,
//   one per transfer; the final result of a request carries last.
//   An idle engine takes a request in the cycle after its transfer.
//   Start/stop gives one acknowledge. Evaluate scans each timer, fires
//   each due timer, runs the bit serial catch-up divider for each
//   periodic timer that missed more than one period, and then scans all
//   timers for the wake time. The engine handles one request at a time;
//   a two-entry queue lets the input side keep taking requests meanwhile.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the
//   user must write them only while the bank is idle, which the block
//   does not enforce. Reset clears all configuration registers and
//   disarms every timer. When the receiver stalls, the result register
//   holds and the engine waits; the queue fills and then the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module periodic_oneshot_timer_bank
  import pot_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [IVW-1:0]  cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [1:0]      timer_index_i,
  input  logic [1:0]      start_mode_i,
  input  logic [TW-1:0]   now_time_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      result_kind_o,
  output logic [1:0]      fired_index_o,
  output logic [CNTW-1:0] fire_count_o,
  output logic [TW-1:0]   wake_time_o,
  output logic            accepted_o,
  output logic            now_running_o,
  output logic            last_o
);

  logic [3:0][IVW-1:0] interval_q;
  logic [3:0]          repeat_q;

  logic  q_full, q_push, q_valid, q_pop;
  cmd_t  q_in, q_out;
  res_t  res;
  logic  is_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      repeat_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IV0:    interval_q[0] <= cfg_data_i;
        CFG_IV1:    interval_q[1] <= cfg_data_i;
        CFG_IV2:    interval_q[2] <= cfg_data_i;
        CFG_IV3:    interval_q[3] <= cfg_data_i;
        CFG_REPEAT: repeat_q      <= cfg_data_i[3:0];
        default:    ;
      endcase
    end
  end

  // front end: classify the request; reserved type is dropped here
  always_comb begin
    is_cmd  = 1'b1;
    q_in.op = OP_EVAL;
    case (req_type_i)
      REQ_EVAL:  q_in.op = OP_EVAL;
      REQ_START: q_in.op = OP_START;
      REQ_STOP:  q_in.op = OP_STOP;
      default:   is_cmd  = 1'b0;
    endcase
    q_in.idx  = timer_index_i;
    q_in.mode = start_mode_i;
    q_in.now  = now_time_i;
  end

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full && is_cmd;

  pot_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  pot_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .interval_i  (interval_q),
    .repeat_i    (repeat_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign result_kind_o = res.kind;
  assign fired_index_o = res.idx;
  assign fire_count_o  = res.cnt;
  assign wake_time_o   = res.wake;
  assign accepted_o    = res.acc;
  assign now_running_o = res.run;
  assign last_o        = res.last;

endmodule

### sim/periodic_oneshot_timer_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives start, stop and evaluate requests with random gaps and result
// stalls, predicts every result from a private timer model and checks
// each result transfer field by field, over several interval/mode settings.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_tb;
  import pot_pkg::*;

  localparam logic [TW-1:0] T_MAX      = {TW{1'b1}};
  localparam logic [1:0]    REQ_NONE   = 2'd3;  // dropped by the bank
  localparam logic [1:0]    SM_INVALID = 2'd3;  // acknowledged, never applied
  localparam int            DRAIN      = 400;   // > worst evaluate latency

  typedef struct {
    logic [1:0]    req;
    logic [1:0]    idx;
    logic [1:0]    mode;
    logic [TW-1:0] now;
  } req_item_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_idx_i = '0;
  logic [IVW-1:0]  cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      req_type_i = '0;
  logic [1:0]      timer_index_i = '0;
  logic [1:0]      start_mode_i = '0;
  logic [TW-1:0]   now_time_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [1:0]      result_kind_o;
  logic [1:0]      fired_index_o;
  logic [CNTW-1:0] fire_count_o;
  logic [TW-1:0]   wake_time_o;
  logic            accepted_o;
  logic            now_running_o;
  logic            last_o;

  periodic_oneshot_timer_bank u_top (.*);

  always #5 clk_i = ~clk_i;

  // Private copy of the bank state and its registers.
  logic [IVW-1:0] ivl [4];
  logic [3:0]     periodic_mask;
  logic [TW-1:0]  expiry [4];
  logic           armed [4];

  req_item_t req_q [$];     // requests not yet transferred
  res_t      result_q [$];  // results owed by the bank, oldest first
  int        errors = 0;
  bit        calm = 0;      // phase without gaps or stalls
  logic [TW-1:0] clock_ms = '0;

  function automatic logic [TW-1:0] add_sat(logic [TW-1:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {16'd0, a} + b;
    return (s > {16'd0, T_MAX}) ? T_MAX : s[TW-1:0];
  endfunction

  function automatic res_t mk_res(logic [1:0] kind, logic [1:0] idx, logic [CNTW-1:0] cnt,
                                  logic [TW-1:0] wake, logic acc, logic run, logic lst);
    res_t r;
    r.kind = kind; r.idx = idx; r.cnt = cnt; r.wake = wake;
    r.acc = acc; r.run = run; r.last = lst;
    return r;
  endfunction

  // Works out the results of one transferred request and updates the state.
  task automatic model_request(req_item_t it);
    logic [63:0]   span, steps;
    logic [TW-1:0] wake;
    logic          go, acc;
    if (it.req == REQ_EVAL) begin
      for (int i = 0; i < 4; i++) begin
        if (!armed[i] || expiry[i] > it.now) continue;
        steps = 1;
        if (periodic_mask[i]) begin
          if (ivl[i] == 0) begin
            expiry[i] = it.now;
          end else begin
            span = it.now - expiry[i];
            if (span > ivl[i]) steps = (span + ivl[i] - 1) / ivl[i];
            expiry[i] = add_sat(expiry[i], steps * ivl[i]);
          end
        end else begin
          armed[i] = 1'b0;
        end
        result_q.push_back(mk_res(RK_FIRE, i[1:0], (steps > 65535) ? 16'hFFFF : steps[15:0],
                                  '0, 1'b0, armed[i], 1'b0));
      end
      wake = add_sat(it.now, WAKE_CAP);
      for (int i = 0; i < 4; i++)
        if (armed[i] && expiry[i] < wake) wake = expiry[i];
      result_q.push_back(mk_res(RK_WAKE, 2'd0, '0, wake, 1'b0, 1'b0, 1'b1));
    end else if (it.req == REQ_START || it.req == REQ_STOP) begin
      acc = 1'b0;
      if (it.req == REQ_STOP) begin
        armed[it.idx] = 1'b0;
        acc = 1'b1;
      end else begin
        go = (it.mode == SM_IDLE && !armed[it.idx]) || it.mode == SM_ALWAYS ||
             (it.mode == SM_RUNNING && armed[it.idx]);
        if (go) begin
          expiry[it.idx] = add_sat(it.now, ivl[it.idx]);
          armed[it.idx] = 1'b1;
          acc = 1'b1;
        end
      end
      result_q.push_back(mk_res(RK_ACK, it.idx, '0, '0, acc, armed[it.idx], 1'b1));
    end
    // request type 3: dropped, nothing owed
  endtask

  task automatic report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Driver: one request per transfer, random gap between requests.
  int gap_left = 0;
  always @(posedge clk_i) begin
    bit busy;
    req_item_t it;
    busy = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      model_request('{req_type_i, timer_index_i, start_mode_i, now_time_i});
      busy = 0;
    end
    if (!busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (req_q.size() > 0) begin
        it = req_q.pop_front();
        req_type_i <= it.req;
        timer_index_i <= it.idx;
        start_mode_i <= it.mode;
        now_time_i <= it.now;
        in_valid_i <= 1'b1;
        gap_left <= calm ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: random stall per result, compare each result transfer.
  int stall_left = 0;
  always @(posedge clk_i) begin
    res_t w;
    if (out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        report("result with nothing outstanding");
      end else begin
        w = result_q.pop_front();
        if (result_kind_o !== w.kind)
          report($sformatf("kind %0d, want %0d", result_kind_o, w.kind));
        if (fired_index_o !== w.idx)
          report($sformatf("index %0d, want %0d", fired_index_o, w.idx));
        if (fire_count_o !== w.cnt)
          report($sformatf("count %0d, want %0d", fire_count_o, w.cnt));
        if (wake_time_o !== w.wake)
          report($sformatf("wake %0d, want %0d", wake_time_o, w.wake));
        if (accepted_o !== w.acc)
          report($sformatf("accepted %0b, want %0b", accepted_o, w.acc));
        if (now_running_o !== w.run)
          report($sformatf("running %0b, want %0b", now_running_o, w.run));
        if (last_o !== w.last)
          report($sformatf("last %0b, want %0b", last_o, w.last));
      end
      stall_left = calm ? 0 : $urandom_range(0, 5);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic cfg_write(logic [2:0] idx, logic [IVW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_REPEAT) periodic_mask = data[3:0];
    else ivl[idx] = data;
  endtask

  task automatic wait_idle();
    while (req_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);  // dropped requests may still be in flight
  endtask

  task automatic push_req(logic [1:0] req, logic [1:0] idx, logic [1:0] mode,
                          logic [TW-1:0] now);
    req_item_t it;
    it.req = req; it.idx = idx; it.mode = mode; it.now = now;
    req_q.push_back(it);
  endtask

  // Mostly start/evaluate traffic on a moving clock, with some noise.
  task automatic random_phase(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_ms = TW'({$urandom, $urandom} & T_MAX);
      else if (pick < 6) clock_ms = add_sat(clock_ms, {$urandom_range(1, 255), 20'd0});
      else clock_ms = add_sat(clock_ms, $urandom_range(0, 1500));
      pick = $urandom_range(0, 99);
      if (pick < 40)
        push_req(REQ_START, 2'($urandom_range(0, 3)),
                 ($urandom_range(0, 19) == 0) ? SM_INVALID : 2'($urandom_range(0, 2)),
                 clock_ms);
      else if (pick < 55)
        push_req(REQ_STOP, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), clock_ms);
      else if (pick < 96)
        push_req(REQ_EVAL, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), clock_ms);
      else
        push_req(REQ_NONE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), clock_ms);
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      ivl[i] = '0; expiry[i] = '0; armed[i] = 1'b0;
    end
    periodic_mask = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, then extremes and odd codes.
    push_req(REQ_EVAL, 2'd0, SM_IDLE, '0);               // nothing armed: cap
    push_req(REQ_START, 2'd0, SM_IDLE, 48'd100);         // zero interval
    push_req(REQ_START, 2'd0, SM_IDLE, 48'd100);         // already running
    push_req(REQ_START, 2'd1, SM_RUNNING, 48'd100);      // idle, refused
    push_req(REQ_START, 2'd2, SM_INVALID, 48'd100);      // bad mode
    push_req(REQ_NONE, 2'd3, SM_ALWAYS, 48'd100);        // dropped
    push_req(REQ_EVAL, 2'd3, SM_INVALID, 48'd100);       // one-shot fires
    push_req(REQ_STOP, 2'd0, SM_IDLE, 48'd101);          // stop an idle timer
    push_req(REQ_START, 2'd3, SM_ALWAYS, T_MAX - 48'd5);
    push_req(REQ_EVAL, 2'd0, SM_IDLE, T_MAX - 48'd10);   // wake cap saturates
    push_req(REQ_EVAL, 2'd0, SM_IDLE, T_MAX);
    wait_idle();

    // Periodic, extreme intervals: zero, all ones, one, small.
    cfg_write(CFG_IV0, 32'd0);
    cfg_write(CFG_IV1, 32'hFFFF_FFFF);
    cfg_write(CFG_IV2, 32'd1);
    cfg_write(CFG_IV3, 32'd7);
    cfg_write(CFG_REPEAT, 32'hF);
    push_req(REQ_START, 2'd0, SM_ALWAYS, 48'd1000);
    push_req(REQ_START, 2'd1, SM_ALWAYS, T_MAX - 48'd70000);  // start sum saturates
    push_req(REQ_START, 2'd2, SM_ALWAYS, 48'd1000);
    push_req(REQ_START, 2'd3, SM_IDLE, 48'd1000);
    push_req(REQ_START, 2'd3, SM_RUNNING, 48'd1003);
    push_req(REQ_EVAL, 2'd0, SM_IDLE, 48'd1000);             // zero interval fires
    push_req(REQ_EVAL, 2'd0, SM_IDLE, 48'd1000 + 48'd200000);// count saturates
    push_req(REQ_EVAL, 2'd0, SM_IDLE, 48'd1000 + 48'd200013);
    push_req(REQ_EVAL, 2'd0, SM_IDLE, T_MAX);                // all fire, catch-up saturates
    push_req(REQ_EVAL, 2'd0, SM_IDLE, T_MAX);
    push_req(REQ_STOP, 2'd1, SM_IDLE, T_MAX);
    push_req(REQ_STOP, 2'd2, SM_IDLE, T_MAX);
    wait_idle();

    // Random phases over several settings.
    for (int ph = 0; ph < 5; ph++) begin
      calm = (ph == 2);
      for (int i = 0; i < 4; i++)
        cfg_write(i[2:0], ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) :
                          ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 3000));
      cfg_write(CFG_REPEAT, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hF : $urandom_range(0, 15));
      clock_ms = (ph == 4) ? T_MAX - 48'd100000 : {16'($urandom_range(0, 65535)), 32'd0};
      random_phase(40);
      wait_idle();
    end

    if (errors == 0) $display("** periodic_oneshot_timer_bank: PASSED **");
    else $display("** periodic_oneshot_timer_bank: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** periodic_oneshot_timer_bank: FAILED **");
    $finish;
  end

endmodule
